@@ hw/rtl/linear_interp_resampler_core_defines.svh @@
// assertion macros for the linear interpolation resampler
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lir_pkg.sv @@
// shared types for the linear interpolation resampler
// no dependencies
`timescale 1ns / 1ps

package lir_pkg;

    // extra integer bits of the rate step above the fraction (ratio up to 16)
    localparam int STEP_INT_BITS = 5;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL1 = 5'b00010,
        S_MUL   = 5'b00100,
        S_EVAL2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/linear_interp_resampler_core.sv @@
// Sequence: an accepted word runs S_EVAL1 and the bit-serial multiply in S_MUL once per
// interpolated output when a previous sample is held, then S_EVAL2 for the held outputs
// on a last word, then S_DONE. One word at a time: the next is accepted only in S_IDLE, and
// output stalls hold S_MUL, S_EVAL2 and S_DONE until the staging register can take a result.
// Reset (sync, active low) clears the stream state and sets rate_step to 1.0.
// Depends on lir_pkg and linear_interp_resampler_core_defines.svh.
`timescale 1ns / 1ps
`include "linear_interp_resampler_core_defines.svh"

module linear_interp_resampler_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [FRAC_BITS+lir_pkg::STEP_INT_BITS-1:0] i_rate_step,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_in_sample,
    input  logic                                        i_in_last,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]              o_out_sample,
    output logic                                        o_run_last,
    output logic                                        o_stream_end
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int STW = FB + lir_pkg::STEP_INT_BITS;
    localparam int PW  = STW + 1;
    localparam int CW  = $clog2(FB);

    localparam logic [STW-1:0] STEP_ONE = STW'(1) << FB;
    localparam logic [STW-1:0] STEP_MIN = STW'(1) << (FB - 4);
    localparam logic [STW-1:0] STEP_MAX = STW'(1) << (FB + 4);
    localparam logic [PW-1:0]  ONE_P    = PW'(1) << FB;
    localparam logic [PW-1:0]  TWO_P    = PW'(2) << FB;

    lir_pkg::t_state r_state, n_state;

    logic [STW-1:0]        r_rate_step, n_rate_step;
    logic [STW-1:0]        r_step, n_step;
    logic [PW-1:0]         r_phase, n_phase;
    logic [SW-1:0]         r_prev, n_prev;
    logic                  r_have_prev, n_have_prev;
    logic [SW-1:0]         r_cur, n_cur;
    logic                  r_last, n_last;

    // bit-serial multiplier: difference times fraction, lsb first
    logic signed [SW:0]    r_mcand, n_mcand;
    logic signed [SW+1:0]  r_acc, n_acc;
    logic [FB-1:0]         r_mplier, n_mplier;
    logic [CW-1:0]         r_cnt, n_cnt;

    // one-deep staging so run_last can be set once the run is known to end
    logic                  r_stg_v, n_stg_v;
    logic [SW-1:0]         r_stg, n_stg;

    logic                  r_out_valid, n_out_valid;
    logic [SW-1:0]         r_out_sample, n_out_sample;
    logic                  r_run_last, n_run_last;
    logic                  r_stream_end, n_stream_end;

    logic [PW-1:0]         phase_sum;
    logic [STW-1:0]        step_sat;
    logic signed [SW+1:0]  mul_add;
    logic signed [SW+1:0]  mul_sum;
    logic signed [SW+1:0]  mul_half;
    logic [SW+1:0]         lerp_sum;
    logic                  out_free;
    logic                  stage_ok;
    logic                  stage_en;
    logic [SW-1:0]         stage_val;

    assign phase_sum = r_phase + {1'b0, r_step};
    assign step_sat  = (r_rate_step < STEP_MIN) ? STEP_MIN :
                       ((r_rate_step > STEP_MAX) ? STEP_MAX : r_rate_step);
    assign mul_add   = r_mplier[0] ? {r_mcand[SW], r_mcand} : '0;
    assign mul_sum   = r_acc + mul_add;
    assign mul_half  = mul_sum >>> 1;
    // prev + floor((d*frac + half) / one): the last bit shifted out is the rounding bit
    assign lerp_sum  = {{2{r_prev[SW-1]}}, r_prev} + mul_half + {{(SW+1){1'b0}}, mul_sum[0]};
    assign out_free  = !r_out_valid || i_out_ready;
    assign stage_ok  = !r_stg_v || out_free;

    assign o_in_ready   = (r_state == lir_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;

    always_comb begin
        n_state      = r_state;
        n_rate_step  = r_rate_step;
        n_step       = r_step;
        n_phase      = r_phase;
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_cur        = r_cur;
        n_last       = r_last;
        n_mcand      = r_mcand;
        n_acc        = r_acc;
        n_mplier     = r_mplier;
        n_cnt        = r_cnt;
        n_stg_v      = r_stg_v;
        n_stg        = r_stg;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_run_last   = r_run_last;
        n_stream_end = r_stream_end;
        stage_en     = 1'b0;
        stage_val    = r_cur;

        if (i_cfg_we) begin
            n_rate_step = i_rate_step;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lir_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cur  = i_in_sample;
                    n_last = i_in_last;
                    n_step = step_sat;
                    if (r_have_prev) begin
                        n_state = lir_pkg::S_EVAL1;
                    end else if (i_in_last) begin
                        n_state = lir_pkg::S_EVAL2;
                    end else begin
                        n_state = lir_pkg::S_DONE;
                    end
                end
            end
            lir_pkg::S_EVAL1: begin
                // on the last word stop once the next position passes the end
                if (r_phase < ONE_P && !(r_last && phase_sum > TWO_P)) begin
                    n_mcand  = {r_cur[SW-1], r_cur} - {r_prev[SW-1], r_prev};
                    n_acc    = '0;
                    n_mplier = r_phase[FB-1:0];
                    n_cnt    = CW'(FB - 1);
                    n_state  = lir_pkg::S_MUL;
                end else begin
                    n_phase = (r_phase >= ONE_P) ? (r_phase - ONE_P) : ONE_P;
                    n_state = r_last ? lir_pkg::S_EVAL2 : lir_pkg::S_DONE;
                end
            end
            lir_pkg::S_MUL: begin
                // the final shift waits until the result can be staged
                if (r_cnt != '0 || stage_ok) begin
                    n_acc    = mul_half;
                    n_mplier = r_mplier >> 1;
                    n_cnt    = r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        stage_en  = 1'b1;
                        stage_val = lerp_sum[SW-1:0];
                        n_phase   = phase_sum;
                        n_state   = lir_pkg::S_EVAL1;
                    end
                end
            end
            lir_pkg::S_EVAL2: begin
                // positions between the last sample and the end hold that sample
                if (r_phase < ONE_P && phase_sum <= ONE_P) begin
                    if (stage_ok) begin
                        stage_en  = 1'b1;
                        stage_val = r_cur;
                        n_phase   = phase_sum;
                    end
                end else begin
                    n_state = lir_pkg::S_DONE;
                end
            end
            lir_pkg::S_DONE: begin
                if (stage_ok) begin
                    if (r_stg_v) begin
                        n_out_valid  = 1'b1;
                        n_out_sample = r_stg;
                        n_run_last   = 1'b1;
                        n_stream_end = r_last;
                        n_stg_v      = 1'b0;
                    end
                    if (r_last) begin
                        n_prev      = '0;
                        n_have_prev = 1'b0;
                        n_phase     = '0;
                    end else begin
                        n_prev      = r_cur;
                        n_have_prev = 1'b1;
                    end
                    n_state = lir_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lir_pkg::S_IDLE;
            end
        endcase

        if (stage_en) begin
            if (r_stg_v) begin
                n_out_valid  = 1'b1;
                n_out_sample = r_stg;
                n_run_last   = 1'b0;
                n_stream_end = 1'b0;
            end
            n_stg_v = 1'b1;
            n_stg   = stage_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lir_pkg::S_IDLE;
            r_rate_step <= STEP_ONE;
            r_phase     <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_stg_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rate_step <= n_rate_step;
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_stg_v     <= n_stg_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_cur        <= n_cur;
        r_last       <= n_last;
        r_mcand      <= n_mcand;
        r_acc        <= n_acc;
        r_mplier     <= n_mplier;
        r_cnt        <= n_cnt;
        r_stg        <= n_stg;
        r_out_sample <= n_out_sample;
        r_run_last   <= n_run_last;
        r_stream_end <= n_stream_end;
    end

    `LIR_ASSERT_IMP(a_end_marks_run, o_out_valid && o_stream_end, o_run_last, "stream end without run end")
    `LIR_ASSERT_IMP(a_mul_in_interval, r_state == lir_pkg::S_MUL, r_phase < ONE_P, "multiply outside interval")
    `LIR_ASSERT_NXT(a_stage_held, r_stg_v && r_out_valid && !i_out_ready, r_stg_v && $stable(r_stg), "staged word lost")
    `LIR_ASSERT_NXT(a_last_clears, r_state == lir_pkg::S_DONE && r_last && !r_stg_v, !r_have_prev && r_phase == '0, "stream state not cleared")
    `LIR_ASSERT_NXT(a_accept_busy, i_in_valid && o_in_ready, r_state != lir_pkg::S_IDLE, "accept did not start work")

endmodule

@@ sim/linear_interp_resampler_core_test.sv @@
// self-checking testbench for linear_interp_resampler_core: streams of samples
// at many rate steps, outputs checked against an in-bench interpolation tracker
// depends on lir_pkg and the resampler rtl
`timescale 1ns / 1ps

module linear_interp_resampler_core_test;

    localparam int SW          = 16;
    localparam int FB          = 16;
    localparam int RATE_W      = FB + lir_pkg::STEP_INT_BITS;
    localparam int DRAIN_WAIT  = 2 + 16 * (FB + 1) + 16 + 30;
    localparam int LONG_HOLD   = 600;
    localparam int WORD_TARGET = 410;

    localparam logic [RATE_W-1:0] RATE_UNITY = 21'h10000;
    localparam logic [RATE_W-1:0] RATE_MIN   = 21'h01000;
    localparam logic [RATE_W-1:0] RATE_MAX   = 21'h100000;
    localparam logic [RATE_W-1:0] RATE_TOP   = 21'h1FFFFF;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 run_last;
        logic                 stream_end;
    } t_out_word;

    // tracks stream position and holds the output words still due
    class resample_tracker;
        localparam longint ONE  = 64'd1 << FB;
        localparam longint HALF = 64'd1 << (FB - 1);

        logic [RATE_W-1:0]    rate_reg;
        logic signed [SW-1:0] prev_sample;
        bit                   have_prev;
        longint               phase_pos;
        t_out_word            due[$];
        int                   errors;
        int                   words_in;
        int                   words_out;
        int                   streams_done;

        function new();
            rate_reg     = RATE_UNITY;
            prev_sample  = '0;
            have_prev    = 1'b0;
            phase_pos    = 0;
            errors       = 0;
            words_in     = 0;
            words_out    = 0;
            streams_done = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] value);
            rate_reg = value;
        endfunction

        function logic signed [SW-1:0] interp(longint a, longint b, longint frac);
            longint acc;
            acc = a * ONE + (b - a) * frac + HALF;
            return SW'(acc >>> FB);
        endfunction

        function void push_due(logic signed [SW-1:0] s);
            t_out_word w;
            w.sample     = s;
            w.run_last   = 1'b0;
            w.stream_end = 1'b0;
            due.push_back(w);
        endfunction

        function void take_sample(logic signed [SW-1:0] cur, logic last);
            longint step;
            longint c;
            int     n_before;
            step     = rate_reg;
            c        = cur;
            n_before = due.size();
            words_in++;
            // out-of-range steps are clamped to 1/16 .. 16
            if (step < longint'(RATE_MIN))
                step = RATE_MIN;
            if (step > longint'(RATE_MAX))
                step = RATE_MAX;
            if (have_prev) begin
                while (phase_pos < ONE) begin
                    if (last && phase_pos + step > 2 * ONE)
                        break;
                    push_due(interp(longint'(prev_sample), c, phase_pos));
                    phase_pos += step;
                end
                if (phase_pos >= ONE)
                    phase_pos -= ONE;
                else
                    phase_pos = ONE;
            end
            if (last) begin
                // hold the final sample for positions that end by the stream end
                while (phase_pos < ONE && phase_pos + step <= ONE) begin
                    push_due(cur);
                    phase_pos += step;
                end
            end
            if (due.size() > n_before) begin
                due[due.size()-1].run_last   = 1'b1;
                due[due.size()-1].stream_end = last;
            end
            if (last) begin
                prev_sample = '0;
                have_prev   = 1'b0;
                phase_pos   = 0;
                streams_done++;
            end else begin
                prev_sample = cur;
                have_prev   = 1'b1;
            end
        endfunction

        function void check_output(logic signed [SW-1:0] s, logic rl, logic se);
            t_out_word w;
            words_out++;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected word sample %0d run_last %0b stream_end %0b",
                             $realtime, s, rl, se);
            end else begin
                w = due.pop_front();
                if (w.sample !== s || w.run_last !== rl || w.stream_end !== se) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: expected sample %0d run_last %0b stream_end %0b, got %0d %0b %0b",
                                 $realtime, w.sample, w.run_last, w.stream_end, s, rl, se);
                end
            end
        endfunction

        function int failures();
            return errors + due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [RATE_W-1:0]    rate_step   = RATE_UNITY;
    logic                 in_valid    = 1'b0;
    logic signed [SW-1:0] in_sample   = '0;
    logic                 in_last     = 1'b0;
    logic                 out_ready   = 1'b0;
    wire                  o_in_ready;
    wire                  o_out_valid;
    wire signed [SW-1:0]  o_out_sample;
    wire                  o_run_last;
    wire                  o_stream_end;

    resample_tracker tracker = new();

    bit quiet         = 1'b0;
    bit send_gaps     = 1'b0;
    bit long_hold_req = 1'b0;
    int rate_settings = 0;

    linear_interp_resampler_core #(
        .SAMPLE_WIDTH(SW),
        .FRAC_BITS   (FB)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_rate_step (rate_step),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_sample (in_sample),
        .i_in_last   (in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_sample(o_out_sample),
        .o_run_last  (o_run_last),
        .o_stream_end(o_stream_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d words still due", tracker.due.size());
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                tracker.take_sample(in_sample, in_last);
            if (o_out_valid && out_ready)
                tracker.check_output(o_out_sample, o_run_last, o_stream_end);
        end
    end

    // output side: random ready bursts in segments, plus one long hold on request
    initial begin : out_side
        int seg_left;
        bit seg_idle;
        seg_left = 0;
        seg_idle = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 300);
                seg_idle = ($urandom_range(0, 2) != 0);
            end
            seg_left--;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && seg_idle && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [SW-1:0] pick_sample();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return SW'($urandom);
    endfunction

    // offer one word; valid stays up afterwards until the next word or an idle
    task automatic send_word(input logic signed [SW-1:0] s, input logic l);
        if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        in_last   <= l;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.due.size() != 0)
            @(posedge i_clk);
        // a word may still be in flight even when it owes no output
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        rate_step <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.set_rate(value);
        rate_settings++;
    endtask

    initial begin : stimulus
        int                phase_len;
        int                len;
        bit                cut;
        logic [RATE_W-1:0] rate_pick;
        logic [RATE_W-1:0] fixed_rates[6];
        fixed_rates = '{RATE_MIN, RATE_MAX, 21'h08000, 21'h20000, 21'h0, RATE_TOP};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unity step: single-sample stream, full-scale swings, open stream left behind
        send_word(16'sh7FFF, 1'b1);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'shFFFF, 1'b0);
        send_word(16'sh0000, 1'b1);
        send_word(16'sh5555, 1'b0);
        send_word(16'shAAAA, 1'b0);

        // zero step clamps to 1/16: sixteen interpolated plus sixteen held words
        write_rate('0);
        send_word(16'sh7FFF, 1'b1);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7FFF, 1'b1);

        // all-ones step clamps to 16: sparse outputs, final word may owe nothing
        write_rate(RATE_TOP);
        send_word(16'sd100, 1'b0);
        send_word(16'sd200, 1'b0);
        send_word(16'sd300, 1'b0);
        send_word(16'sd400, 1'b1);
        send_word(-16'sd5, 1'b0);
        send_word(16'sd7, 1'b1);

        write_rate(RATE_MAX);
        send_word(16'sd1000, 1'b1);
        send_word(16'sd1, 1'b0);
        send_word(16'sd2, 1'b0);

        // step change with a stream still open
        write_rate(21'h18000);
        send_word(16'sd3, 1'b0);
        send_word(16'sd4, 1'b1);

        // random phases: streams of random length, some phases end mid-stream
        for (int ph = 0; tracker.words_in < WORD_TARGET; ph++) begin
            if (ph < 6)
                rate_pick = fixed_rates[ph];
            else if ($urandom_range(0, 2) != 0)
                rate_pick = RATE_W'($urandom_range(4096, 139264));
            else
                rate_pick = RATE_W'($urandom_range(0, 2097151));
            write_rate(rate_pick);
            send_gaps = ($urandom_range(0, 3) != 0);
            if (tracker.words_in >= WORD_TARGET - 60)
                quiet = 1'b1;
            // dense output rate while the receiver holds off fills the block
            if (ph == 0)
                long_hold_req = 1'b1;
            phase_len = $urandom_range(20, 45);
            while (phase_len > 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                cut = 1'b0;
                if (len >= phase_len) begin
                    cut = ($urandom_range(0, 2) == 0);
                    if (cut)
                        len = phase_len;
                end
                for (int i = 0; i < len; i++)
                    send_word(pick_sample(), (i == len - 1) && !cut);
                phase_len -= len;
            end
        end

        wait_idle();
        $display("%0d words in, %0d words out, %0d streams closed",
                 tracker.words_in, tracker.words_out, tracker.streams_done);
        $display("%0d rate step settings including clamped extremes and mid-stream changes",
                 rate_settings);
        if (tracker.failures() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", tracker.failures());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lir_pkg.sv
hw/rtl/linear_interp_resampler_core.sv
sim/linear_interp_resampler_core_test.sv
